### src/sida_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_pkg
// Shared types and constants for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package sida_pkg;

   // input word and decimal digit store
   localparam int MagWidth   = 32;
   localparam int NumDigits  = 10;
   localparam int BcdWidth   = NumDigits * 4;
   localparam int CntWidth   = $clog2(MagWidth);
   localparam int IdxWidth   = $clog2(NumDigits);
   localparam int CharWidth  = 6;

   // character codes
   localparam logic [CharWidth-1:0] CharZero  = 6'd48;
   localparam logic [CharWidth-1:0] CharMinus = 6'd45;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SCAN,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic shift;
      logic scan;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic shift_done;
      logic digit_last;
      logic neg;
      logic out_free;
   } status_type;

endpackage

### src/sida_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_dp
// Datapath: magnitude forming, shift-and-add-3 binary to BCD conversion,
// leading digit search and the result register.
// ----------------------------------------------------------------------------
module sida_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  sida_pkg::cmd_type                   cmd,
   output sida_pkg::status_type                status,
   input  logic signed [sida_pkg::MagWidth-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sida_pkg::CharWidth-1:0]      rsp_char_code,
   output logic                                rsp_last
);

   logic [sida_pkg::MagWidth-1:0]  mag_ff, mag_in;
   logic [sida_pkg::BcdWidth-1:0]  bcd_ff, bcd_in, bcd_adj;
   logic [sida_pkg::CntWidth-1:0]  cnt_ff, cnt_in;
   logic [sida_pkg::IdxWidth-1:0]  idx_ff, idx_in, idx_top;
   logic                           neg_ff, neg_in;
   logic [sida_pkg::CharWidth-1:0] char_ff, char_in;
   logic                           last_ff, last_in;
   logic                           valid_ff, valid_in;
   logic [3:0]                     cur_digit;
   logic                           out_free;

   // add 3 to every digit of five or more ahead of the shift
   always_comb begin
      for (int i = 0; i < sida_pkg::NumDigits; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   // index of the most significant non-zero digit, zero when all are zero
   always_comb begin
      idx_top = '0;
      for (int i = 0; i < sida_pkg::NumDigits; i++) begin
         if (bcd_ff[i*4 +: 4] != 4'd0) begin
            idx_top = i[sida_pkg::IdxWidth-1:0];
         end
      end
   end

   assign cur_digit = bcd_ff[idx_ff*4 +: 4];
   assign out_free  = !valid_ff || !rsp_stall;

   // conversion registers
   always_comb begin
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      neg_in = neg_ff;
      if (cmd.load) begin
         neg_in = req_value[sida_pkg::MagWidth-1];
         mag_in = neg_in ? (sida_pkg::MagWidth'(0) - req_value) : req_value;
         bcd_in = '0;
         cnt_in = '0;
      end
      if (cmd.shift) begin
         {bcd_in, mag_in} = {bcd_adj[sida_pkg::BcdWidth-2:0], mag_ff, 1'b0};
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.scan) begin
         idx_in = idx_top;
      end
      if (cmd.emit_digit) begin
         idx_in = idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      idx_ff <= idx_in;
      neg_ff <= neg_in;
   end

   // result register
   always_comb begin
      char_in  = char_ff;
      last_in  = last_ff;
      valid_in = valid_ff && rsp_stall;
      if (cmd.emit_sign) begin
         char_in  = sida_pkg::CharMinus;
         last_in  = 1'b0;
         valid_in = 1'b1;
      end
      if (cmd.emit_digit) begin
         char_in  = sida_pkg::CharZero + {2'b00, cur_digit};
         last_in  = (idx_ff == '0);
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign status.shift_done = (cnt_ff == sida_pkg::CntWidth'(sida_pkg::MagWidth - 1));
   assign status.digit_last = (idx_ff == '0);
   assign status.neg        = neg_ff;
   assign status.out_free   = out_free;

   assign rsp_valid     = valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;

endmodule

### src/sida_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_ctrl
// Controller: sequences load, 32 conversion shifts, digit search and the
// character output of one value.
// ----------------------------------------------------------------------------
module sida_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sida_pkg::status_type status,
   output sida_pkg::cmd_type    cmd
);

   sida_pkg::state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sida_pkg::ST_IDLE: begin
            if (req_valid) state_in = sida_pkg::ST_CONV;
         end
         sida_pkg::ST_CONV: begin
            if (status.shift_done) state_in = sida_pkg::ST_SCAN;
         end
         sida_pkg::ST_SCAN: begin
            state_in = status.neg ? sida_pkg::ST_SIGN : sida_pkg::ST_DIGITS;
         end
         sida_pkg::ST_SIGN: begin
            if (status.out_free) state_in = sida_pkg::ST_DIGITS;
         end
         sida_pkg::ST_DIGITS: begin
            if (status.out_free && status.digit_last) state_in = sida_pkg::ST_IDLE;
         end
         default: state_in = sida_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sida_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         sida_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         sida_pkg::ST_CONV:   cmd.shift      = 1'b1;
         sida_pkg::ST_SCAN:   cmd.scan       = 1'b1;
         sida_pkg::ST_SIGN:   cmd.emit_sign  = status.out_free;
         sida_pkg::ST_DIGITS: cmd.emit_digit = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

### src/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// Each value is loaded at the input transfer, converted by the 32 single-bit shifts of the BCD
// converter and scanned for its leading digit; then 1 to 11 characters (sign first if negative)
// leave one character per cycle while rsp_stall is low; the next value is taken after the last.
// The last character may still wait in the output register while the next value loads.
// Reset: synchronous, clears the controller state and the output valid flag.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit value into decimal ASCII characters, most
// significant first, with a leading minus sign for negative values and a last-character flag.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [sida_pkg::MagWidth-1:0] req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sida_pkg::CharWidth-1:0]       rsp_char_code,
   output logic                                 rsp_last
);

   sida_pkg::cmd_type    cmd;
   sida_pkg::status_type status;

   // sequencing
   sida_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // conversion and result register
   sida_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   // no new value is taken straight after a transfer in
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken on two consecutive cycles");

   // a minus sign never ends a number
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_last && rsp_char_code == sida_pkg::CharMinus))
      else $error("minus sign flagged as last character");

   // a held result is not overwritten while stalled
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_char_code) && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule
